/* hdl/toi_pkg.sv */
// Shared constants and types for the two-opt tour improver.
package toi_pkg;
   localparam int MaxCities = 128;
   localparam int CityBits = 7;
   localparam int DistBits = 32;
   localparam int LenBits = 39;
   localparam int PassBits = 10;
   localparam int CountBits = 8;
   localparam int DistAddrBits = 2 * CityBits;
   localparam int MinTour = 4;

   typedef enum logic [1:0] {
      OP_LOAD_DIST = 2'd0,
      OP_LOAD_TOUR = 2'd1,
      OP_OPTIMIZE = 2'd2,
      OP_READ_TOUR = 2'd3
   } op_type;

   localparam logic CSR_CITY_COUNT = 1'b0;
   localparam logic CSR_PASS_LIMIT = 1'b1;

   localparam logic KIND_OPT = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [CityBits-1:0] row_city;
      logic [CityBits-1:0] col_city;
      logic [DistBits-1:0] distance;
      logic [CityBits-1:0] position;
      logic [CityBits-1:0] city;
   } req_type;

   typedef struct packed {
      logic kind;
      logic [LenBits-1:0] total_length;
      logic [PassBits-1:0] passes_used;
      logic converged;
      logic [CityBits-1:0] city_out;
   } rsp_type;

   typedef struct packed {
      logic we;
      logic [CityBits-1:0] waddr;
      logic [CityBits-1:0] wdata;
      logic [CityBits-1:0] raddr;
   } tour_port_type;

   typedef struct packed {
      logic we;
      logic [DistAddrBits-1:0] waddr;
      logic [DistBits-1:0] wdata;
      logic [DistAddrBits-1:0] raddr;
   } dist_port_type;
endpackage

/* hdl/toi_stream_if.sv */
// Valid/ready channel interface.
interface toi_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/toi_tour_mem.sv */
// Tour memory: one write and one registered read port.
module toi_tour_mem
   import toi_pkg::*;
(
   input logic clock,
   input tour_port_type port,
   output logic [CityBits-1:0] rdata
);
   logic [CityBits-1:0] mem [MaxCities];
   always_ff @(posedge clock) begin
      if (port.we) mem[port.waddr] <= port.wdata;
      rdata <= mem[port.raddr];
   end
endmodule

/* hdl/toi_dist_mem.sv */
// Distance memory: one write and one registered read port.
module toi_dist_mem
   import toi_pkg::*;
(
   input logic clock,
   input dist_port_type port,
   output logic [DistBits-1:0] rdata
);
   logic [DistBits-1:0] mem [MaxCities*MaxCities];
   always_ff @(posedge clock) begin
      if (port.we) mem[port.waddr] <= port.wdata;
      rdata <= mem[port.raddr];
   end
endmodule

/* hdl/toi_ctrl.sv */
// Sequencer for loads, reads, 2-opt passes, reversal and length sum.
module toi_ctrl
   import toi_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input req_type in_data,
   output logic out_valid,
   input logic out_ready,
   output rsp_type out_data,
   input logic [CountBits-1:0] city_count,
   input logic [PassBits-1:0] pass_limit,
   output tour_port_type tport,
   input logic [CityBits-1:0] trdata,
   output dist_port_type dport,
   input logic [DistBits-1:0] drdata
);
   typedef enum logic [4:0] {
      S_IDLE, S_RD_WAIT, S_PASS_START, S_T0, S_T1, S_T2, S_T3, S_T4,
      S_D0, S_D1, S_D2, S_D3, S_D4, S_CMP,
      S_RV0, S_RV1, S_RV2, S_RV3,
      S_L0, S_L1, S_L2, S_L3, S_DONE
   } state_type;

   state_type state_ff;
   logic [CityBits:0] n_ff;
   logic [CityBits:0] i_ff, k_ff, lo_ff, hi_ff, p_ff;
   logic [CityBits-1:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [PassBits-1:0] pass_ff;
   logic moved_ff, conv_ff;
   logic [DistBits:0] add_ff, rem_ff;
   logic [LenBits:0] sum_ff;
   logic [CityBits-1:0] swap_ff;
   logic out_valid_ff;
   rsp_type out_ff;
   logic [CityBits:0] nx;
   logic [CountBits-1:0] n_in;

   assign nx = (k_ff + 1'b1 == n_ff) ? '0 : k_ff + 1'b1;
   assign n_in = (city_count > CountBits'(MaxCities)) ? CountBits'(MaxCities) : city_count;
   assign in_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_ff;

   always_comb begin
      tport = '0;
      dport = '0;
      unique case (state_ff)
         S_IDLE: begin
            tport.raddr = in_data.position;
            tport.we = in_valid && in_ready && (in_data.op == OP_LOAD_TOUR);
            tport.waddr = in_data.position;
            tport.wdata = in_data.city;
            dport.we = in_valid && in_ready && (in_data.op == OP_LOAD_DIST);
            dport.waddr = {in_data.row_city, in_data.col_city};
            dport.wdata = in_data.distance;
         end
         S_T0: tport.raddr = CityBits'(i_ff - 1'b1);
         S_T1: tport.raddr = CityBits'(i_ff);
         S_T2: tport.raddr = CityBits'(k_ff);
         S_T3: tport.raddr = CityBits'(nx);
         S_D0: dport.raddr = {ca_ff, cc_ff};
         S_D1: dport.raddr = {cb_ff, cd_ff};
         S_D2: dport.raddr = {ca_ff, cb_ff};
         S_D3: dport.raddr = {cc_ff, cd_ff};
         S_RV0: tport.raddr = CityBits'(lo_ff);
         S_RV1: tport.raddr = CityBits'(hi_ff);
         S_RV2: begin
            tport.we = 1'b1;
            tport.waddr = CityBits'(lo_ff);
            tport.wdata = trdata;
         end
         S_RV3: begin
            tport.we = 1'b1;
            tport.waddr = CityBits'(hi_ff);
            tport.wdata = swap_ff;
         end
         S_L0: tport.raddr = CityBits'(p_ff);
         S_L1: tport.raddr = CityBits'((p_ff + 1'b1 == n_ff) ? '0 : p_ff + 1'b1);
         S_L2: dport.raddr = {ca_ff, trdata};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (in_valid && in_ready) begin
               if (in_data.op == OP_READ_TOUR) state_ff <= S_RD_WAIT;
               else if (in_data.op == OP_OPTIMIZE) begin
                  n_ff <= n_in;
                  pass_ff <= '0;
                  moved_ff <= 1'b0;
                  sum_ff <= '0;
                  p_ff <= '0;
                  if (n_in < CountBits'(MinTour)) begin
                     conv_ff <= 1'b1;
                     state_ff <= (n_in == '0) ? S_DONE : S_L0;
                  end else begin
                     conv_ff <= 1'b0;
                     state_ff <= S_PASS_START;
                  end
               end
            end
            S_RD_WAIT: begin
               out_ff <= '{KIND_READ, '0, '0, 1'b0, trdata};
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_PASS_START: begin
               if (pass_ff == pass_limit) begin
                  conv_ff <= (pass_ff != '0) && !moved_ff;
                  state_ff <= S_L0;
               end else if (pass_ff != '0 && !moved_ff) begin
                  conv_ff <= 1'b1;
                  state_ff <= S_L0;
               end else begin
                  i_ff <= (CityBits+1)'(1);
                  k_ff <= (CityBits+1)'(2);
                  moved_ff <= 1'b0;
                  state_ff <= S_T0;
               end
            end
            S_T0: state_ff <= S_T1;
            S_T1: begin ca_ff <= trdata; state_ff <= S_T2; end
            S_T2: begin cb_ff <= trdata; state_ff <= S_T3; end
            S_T3: begin cc_ff <= trdata; state_ff <= S_T4; end
            S_T4: begin cd_ff <= trdata; state_ff <= S_D0; end
            S_D0: state_ff <= S_D1;
            S_D1: begin add_ff <= {1'b0, drdata}; state_ff <= S_D2; end
            S_D2: begin add_ff <= add_ff + {1'b0, drdata}; state_ff <= S_D3; end
            S_D3: begin rem_ff <= {1'b0, drdata}; state_ff <= S_D4; end
            S_D4: begin rem_ff <= rem_ff + {1'b0, drdata}; state_ff <= S_CMP; end
            S_CMP: begin
               if (add_ff < rem_ff) begin
                  moved_ff <= 1'b1;
                  pass_ff <= pass_ff + 1'b1;
                  lo_ff <= i_ff;
                  hi_ff <= k_ff;
                  state_ff <= S_RV0;
               end else if (k_ff + 1'b1 < n_ff) begin
                  k_ff <= k_ff + 1'b1;
                  state_ff <= S_T0;
               end else if (i_ff + 2'd2 < n_ff) begin
                  i_ff <= i_ff + 1'b1;
                  k_ff <= i_ff + 2'd2;
                  state_ff <= S_T0;
               end else begin
                  pass_ff <= pass_ff + 1'b1;
                  state_ff <= S_PASS_START;
               end
            end
            S_RV0: state_ff <= (lo_ff < hi_ff) ? S_RV1 : S_PASS_START;
            S_RV1: begin swap_ff <= trdata; state_ff <= S_RV2; end
            S_RV2: state_ff <= S_RV3;
            S_RV3: begin
               lo_ff <= lo_ff + 1'b1;
               hi_ff <= hi_ff - 1'b1;
               state_ff <= S_RV0;
            end
            S_L0: state_ff <= S_L1;
            S_L1: begin ca_ff <= trdata; state_ff <= S_L2; end
            S_L2: state_ff <= S_L3;
            S_L3: begin
               sum_ff <= sum_ff + (LenBits+1)'(drdata);
               if (p_ff + 1'b1 == n_ff) state_ff <= S_DONE;
               else begin
                  p_ff <= p_ff + 1'b1;
                  state_ff <= S_L0;
               end
            end
            S_DONE: begin
               out_ff <= '{KIND_OPT,
                  (sum_ff[LenBits] ? {LenBits{1'b1}} : sum_ff[LenBits-1:0]),
                  pass_ff, conv_ff, '0};
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* hdl/two_opt_tour_improver_unit.sv */
// Top level of the two-opt tour improver.
// Channels: req (op, cities, distance, position) in; rsp (results) out;
// csr write port sets city_count (index 0) and pass_limit (index 1).
// Loads give no response. A read answers through the tour memory's read
// register and the response register. Optimize tries each candidate move
// with four tour reads then four distance reads through one port each,
// and the compare; a reversal swaps tour entries pair by pair from both
// ends inward; the closing sum reads two tour entries and a distance per city.
// One item is worked on at a time; the next request is taken once the
// response register is empty.
// Reset clears the sequencer and sets city_count to 128 and pass_limit
// to 4; the memories hold undefined data until loaded.
// When the receiver stalls, the response holds in its register and no
// new request is taken.
module two_opt_tour_improver_unit
   import toi_pkg::*;
(
   input logic clock,
   input logic reset,
   toi_stream_if.sink req,
   toi_stream_if.source rsp,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [PassBits-1:0] csr_write_data
);
   logic [CountBits-1:0] city_count_ff;
   logic [PassBits-1:0] pass_limit_ff;
   tour_port_type tport;
   dist_port_type dport;
   logic [CityBits-1:0] trdata;
   logic [DistBits-1:0] drdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CountBits'(MaxCities);
         pass_limit_ff <= PassBits'(4);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_CITY_COUNT) city_count_ff <= csr_write_data[CountBits-1:0];
         else pass_limit_ff <= csr_write_data;
      end
   end

   toi_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data),
      .city_count(city_count_ff), .pass_limit(pass_limit_ff),
      .tport(tport), .trdata(trdata), .dport(dport), .drdata(drdata)
   );
   toi_tour_mem u_tour (.clock(clock), .port(tport), .rdata(trdata));
   toi_dist_mem u_dist (.clock(clock), .port(dport), .rdata(drdata));
endmodule

/* hdl/toi_checker.sv */
// Port checker for the two-opt tour improver, bound to the top level.
module toi_checker
   import toi_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req taken while rsp pending");
   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_READ |-> rsp_data.passes_used == '0)
      else $error("read rsp carries pass count");
   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp after reset");
endmodule

bind two_opt_tour_improver_unit toi_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
